>>> hw/rtl/edab_pkg.sv
`default_nettype none

package edab_pkg;

	// Elapsed stopwatch width (saturating)
	localparam int ELAPSED_BITS = 18;
	localparam int CMP_W        = (ELAPSED_BITS > 17) ? ELAPSED_BITS : 17;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STAGE_ONE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STAGE_TWO    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLICK_ON     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BEEP_ON      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_ON    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SINGLE_GAP   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_GAP    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_TRAILING_GAP = 3'd7;

	// Pattern kinds, also the stage output code
	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_CLICK  = 2'd1;
	localparam logic [1:0] KIND_BEEP   = 2'd2;
	localparam logic [1:0] KIND_DOUBLE = 2'd3;

	// Reset values of the registers
	localparam logic [15:0] RST_STAGE_ONE    = 16'd60000;
	localparam logic [15:0] RST_STAGE_TWO    = 16'd60000;
	localparam logic [7:0]  RST_CLICK_ON     = 8'd5;
	localparam logic [7:0]  RST_BEEP_ON      = 8'd20;
	localparam logic [7:0]  RST_DOUBLE_ON    = 8'd40;
	localparam logic [15:0] RST_SINGLE_GAP   = 16'd1500;
	localparam logic [15:0] RST_INNER_GAP    = 16'd200;
	localparam logic [15:0] RST_TRAILING_GAP = 16'd1000;

	typedef struct packed {
		logic [15:0] stage_one_ms;
		logic [15:0] stage_two_ms;
		logic [7:0]  click_on_ms;
		logic [7:0]  beep_on_ms;
		logic [7:0]  double_on_ms;
		logic [15:0] single_gap_ms;
		logic [15:0] inner_gap_ms;
		logic [15:0] trailing_gap_ms;
	} cfg_t;

	// Result word, buzzer in the lowest bit
	typedef struct packed {
		logic [1:0] stage;
		logic       alarm_active;
		logic       buzzer;
	} result_t;

	// Length of one phase of a pattern; zero lasts one ms
	function automatic logic [15:0] phase_len(input logic [1:0] kind, input logic [2:0] phase,
			input cfg_t cfg);
		logic [15:0] len;
		if (kind == KIND_DOUBLE) begin
			if (phase == 3'd0 || phase == 3'd2) begin
				len = {8'd0, cfg.double_on_ms};
			end else if (phase == 3'd1) begin
				len = cfg.inner_gap_ms;
			end else begin
				len = cfg.trailing_gap_ms;
			end
		end else if (phase == 3'd0) begin
			len = (kind == KIND_CLICK) ? {8'd0, cfg.click_on_ms} : {8'd0, cfg.beep_on_ms};
		end else begin
			len = cfg.single_gap_ms;
		end
		return (len == 16'd0) ? 16'd1 : len;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/edab_cfg.sv
`default_nettype none

// Configuration register file
module edab_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic [edab_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [edab_pkg::CFG_DATA_W-1:0] wr_data,
	output edab_pkg::cfg_t                       cfg
);

	edab_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stage_one_ms    <= edab_pkg::RST_STAGE_ONE;
			cfg_q.stage_two_ms    <= edab_pkg::RST_STAGE_TWO;
			cfg_q.click_on_ms     <= edab_pkg::RST_CLICK_ON;
			cfg_q.beep_on_ms      <= edab_pkg::RST_BEEP_ON;
			cfg_q.double_on_ms    <= edab_pkg::RST_DOUBLE_ON;
			cfg_q.single_gap_ms   <= edab_pkg::RST_SINGLE_GAP;
			cfg_q.inner_gap_ms    <= edab_pkg::RST_INNER_GAP;
			cfg_q.trailing_gap_ms <= edab_pkg::RST_TRAILING_GAP;
		end else if (wr_en) begin
			unique case (wr_index)
				edab_pkg::REG_STAGE_ONE:    cfg_q.stage_one_ms    <= wr_data;
				edab_pkg::REG_STAGE_TWO:    cfg_q.stage_two_ms    <= wr_data;
				edab_pkg::REG_CLICK_ON:     cfg_q.click_on_ms     <= wr_data[7:0];
				edab_pkg::REG_BEEP_ON:      cfg_q.beep_on_ms      <= wr_data[7:0];
				edab_pkg::REG_DOUBLE_ON:    cfg_q.double_on_ms    <= wr_data[7:0];
				edab_pkg::REG_SINGLE_GAP:   cfg_q.single_gap_ms   <= wr_data;
				edab_pkg::REG_INNER_GAP:    cfg_q.inner_gap_ms    <= wr_data;
				edab_pkg::REG_TRAILING_GAP: cfg_q.trailing_gap_ms <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> hw/rtl/edab_core.sv
`default_nettype none

// Alarm state and pattern sequencer, one tick per step
module edab_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic          door,
	input  wire edab_pkg::cfg_t cfg,
	output edab_pkg::result_t  res
);

	localparam logic [edab_pkg::ELAPSED_BITS-1:0] ELAPSED_MAX = {edab_pkg::ELAPSED_BITS{1'b1}};

	logic                             last_q, start_q, run_q;
	logic [edab_pkg::ELAPSED_BITS-1:0] elapsed_q;
	logic [1:0]                       kind_q;
	logic [2:0]                       phase_q;
	logic [15:0]                      count_q;

	logic                             last_n, start_n, run_n;
	logic [edab_pkg::ELAPSED_BITS-1:0] elapsed_n;
	logic [1:0]                       kind_n;
	logic [2:0]                       phase_n;
	logic [15:0]                      count_n;

	logic [16:0]                      stage_sum;
	logic [15:0]                      count_inc, len;
	logic [2:0]                       phase_inc, phase_total;
	logic                             buzz;
	logic [1:0]                       stage;

	assign stage_sum = {1'b0, cfg.stage_one_ms} + {1'b0, cfg.stage_two_ms};

	// Next state for one tick
	always_comb begin
		last_n      = door;
		start_n     = start_q | (door & ~last_q);
		run_n       = run_q;
		elapsed_n   = elapsed_q;
		kind_n      = kind_q;
		phase_n     = phase_q;
		count_n     = count_q;
		buzz        = 1'b0;
		stage       = edab_pkg::KIND_NONE;
		count_inc   = 16'd0;
		len         = 16'd0;
		phase_inc   = 3'd0;
		phase_total = 3'd0;

		// pick a new pattern only between patterns
		if (kind_q == edab_pkg::KIND_NONE) begin
			if (run_q && !door) begin
				run_n = 1'b0;
			end
			if (start_n && !run_n) begin
				run_n     = 1'b1;
				start_n   = 1'b0;
				elapsed_n = '0;
			end
			if (run_n) begin
				if (edab_pkg::CMP_W'(elapsed_n) < edab_pkg::CMP_W'(cfg.stage_one_ms)) begin
					kind_n = edab_pkg::KIND_CLICK;
				end else if (edab_pkg::CMP_W'(elapsed_n) < edab_pkg::CMP_W'(stage_sum)) begin
					kind_n = edab_pkg::KIND_BEEP;
				end else begin
					kind_n = edab_pkg::KIND_DOUBLE;
				end
				phase_n = 3'd0;
				count_n = 16'd0;
			end
		end

		// play the current pattern
		if (kind_n != edab_pkg::KIND_NONE) begin
			stage       = kind_n;
			buzz        = ~phase_n[0];
			count_inc   = count_n + 16'd1;
			len         = edab_pkg::phase_len(kind_n, phase_n, cfg);
			phase_total = (kind_n == edab_pkg::KIND_DOUBLE) ? 3'd4 : 3'd2;
			if (count_inc >= len) begin
				count_n   = 16'd0;
				phase_inc = phase_n + 3'd1;
				if (phase_inc >= phase_total) begin
					kind_n  = edab_pkg::KIND_NONE;
					phase_n = 3'd0;
				end else begin
					phase_n = phase_inc;
				end
			end else begin
				count_n = count_inc;
			end
		end

		// saturating stopwatch
		if (run_n && elapsed_n != ELAPSED_MAX) begin
			elapsed_n = elapsed_n + edab_pkg::ELAPSED_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q    <= 1'b0;
			start_q   <= 1'b1;
			run_q     <= 1'b0;
			elapsed_q <= '0;
			kind_q    <= edab_pkg::KIND_NONE;
			phase_q   <= 3'd0;
			count_q   <= 16'd0;
		end else if (step) begin
			last_q    <= last_n;
			start_q   <= start_n;
			run_q     <= run_n;
			elapsed_q <= elapsed_n;
			kind_q    <= kind_n;
			phase_q   <= phase_n;
			count_q   <= count_n;
		end
	end

	assign res.buzzer       = buzz;
	assign res.alarm_active = run_n;
	assign res.stage        = stage;

endmodule

`default_nettype wire

>>> hw/rtl/escalating_door_alarm_beeper_unit.sv
// Channel  Direction  Ports                                  Word
// s_       in         s_tvalid s_tready s_tdata[7:0]        door_open
// m_       out        m_tvalid m_tready m_tdata[7:0]        buzzer, alarm_active, stage
// cfg_     in         cfg_valid cfg_ready cfg_index cfg_data register write
//
// One word per cycle while m_tready is high; input register, then result register.
// The tick logic sits between the input register and the result register.
// Reset clears the alarm state, sets the start request and loads default registers.
// A stalled result register holds the input register; the input side stays ready
// while the input register is empty or can move on in the same cycle.
// Configuration writes are always taken.
`default_nettype none

module escalating_door_alarm_beeper_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [7:0]                      s_tdata,   // [0] door_open, rest zero
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [7:0]                           m_tdata,   // [0] buzzer, [1] alarm_active, [3:2] stage
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [edab_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [edab_pkg::CFG_DATA_W-1:0] cfg_data
);

	edab_pkg::cfg_t    cfg;
	edab_pkg::result_t res;
	edab_pkg::result_t res_q;

	logic valid_s1, door_s1;
	logic out_valid_q;
	logic advance;

	assign cfg_ready = 1'b1;

	edab_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// input word moves to the result register when it is free or being drained
	assign advance  = valid_s1 & (~out_valid_q | m_tready);
	assign s_tready = ~valid_s1 | advance;

	edab_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.door   (door_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			door_s1 <= s_tdata[0];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, res_q};

endmodule

`default_nettype wire
